[rtl/sdss_pkg.sv]
// Package for the steepest downward slope search unit.
// Holds shared constants, codes and the controller/datapath command and status types.
// No dependencies.
package sdss_pkg;

  localparam int MAX_SIDE = 64;
  localparam int COORD_W  = 6;
  localparam int SIZE_W   = 7;
  localparam int PIX_W    = 8;
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int NUM_W    = 2 * PIX_W;
  localparam int D2_W     = 2 * COORD_W + 1;
  localparam int QUO_W    = 32;
  localparam int SLOPE_W  = 16;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIDE);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic pix_wr;
    logic q_start;
    logic px_load;
    logic scan;
    logic div_start;
    logic div_run;
    logic sqrt_run;
    logic out_load;
    logic out_bad;
  } cmd_t;

  typedef struct packed {
    logic in_inside;
    logic scan_last;
    logic pipe_busy;
    logic div_last;
    logic sqrt_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/steepest_downward_slope_search_unit.sv]
// Top level of the steepest downward slope search unit.
// Joins the controller sdss_ctrl and the datapath sdss_dp; depends on sdss_pkg.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_action, in_x, in_y, in_pixel
//   out_    | output    | out_valid/out_stall | out_slope_q8, out_bad_coord
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A write item is done in the idle state, which goes on taking items. A query's time is set by the
// single read port of the pixel memory, which is visited once per pixel, plus a 32-step
// divider and a 16-step root. A query outside the image returns a bad-coordinate result; a write outside it is dropped.
// Reset is synchronous and needs no clearing pass; unwritten pixels read as unknown.
// Out stalls hold the result register; a new item is taken once the last query is finished.
module steepest_downward_slope_search_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [sdss_pkg::COORD_W-1:0]  in_x,
  input  logic [sdss_pkg::COORD_W-1:0]  in_y,
  input  logic [sdss_pkg::PIX_W-1:0]    in_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdss_pkg::SLOPE_W-1:0]  out_slope_q8,
  output logic                          out_bad_coord,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [sdss_pkg::SIZE_W-1:0]   cfg_data
);

  sdss_pkg::cmd_t cmd;
  sdss_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sdss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  sdss_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_pixel      (in_pixel),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_slope_q8  (out_slope_q8),
    .out_bad_coord (out_bad_coord)
  );

endmodule

[rtl/sdss_ctrl.sv]
// Controller state machine of the steepest downward slope search unit.
// Sequences accept, scan, divide, square root and result hand-off.
// Depends on sdss_pkg.
module sdss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_action,
  input  sdss_pkg::sts_t sts,
  output logic          in_stall,
  output sdss_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIX   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_BAD   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == sdss_pkg::ACT_WRITE) begin
            cmd.pix_wr = sts.in_inside;
          end else if (sts.in_inside) begin
            cmd.q_start = 1'b1;
            state_nxt   = S_PIX;
          end else begin
            state_nxt = S_BAD;
          end
        end
      end
      S_PIX: begin
        cmd.px_load = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_run = 1'b1;
        if (sts.sqrt_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_bad  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/sdss_dp.sv]
// Datapath of the steepest downward slope search unit.
// Holds the pixel memory, size registers, scan pipeline, divider, root and result register.
// Depends on sdss_pkg.
module sdss_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdss_pkg::cmd_t                cmd,
  output sdss_pkg::sts_t                sts,
  input  logic [sdss_pkg::COORD_W-1:0]  in_x,
  input  logic [sdss_pkg::COORD_W-1:0]  in_y,
  input  logic [sdss_pkg::PIX_W-1:0]    in_pixel,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [sdss_pkg::SIZE_W-1:0]   cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdss_pkg::SLOPE_W-1:0]  out_slope_q8,
  output logic                          out_bad_coord
);

  localparam int CW = sdss_pkg::COORD_W;
  localparam int SW = sdss_pkg::SIZE_W;
  localparam int PW = sdss_pkg::PIX_W;
  localparam int AW = sdss_pkg::ADDR_W;
  localparam int NW = sdss_pkg::NUM_W;
  localparam int DW = sdss_pkg::D2_W;
  localparam int QW = sdss_pkg::QUO_W;
  localparam int RW = sdss_pkg::SLOPE_W;

  logic [PW-1:0] mem [2**AW];
  logic [PW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;

  logic [SW-1:0] width_r, height_r;
  logic [SW-1:0] cfg_clamped;

  logic [CW-1:0] px_x_r, px_y_r;
  logic [PW-1:0] px_v_r;
  logic [CW-1:0] qx_r, qy_r;
  logic          s1_v_r;
  logic [CW-1:0] s1_qx_r, s1_qy_r;
  logic          s2_v_r;
  logic [NW-1:0] s2_num_r;
  logic [DW-1:0] s2_d2_r;
  logic [NW-1:0] best_num_r;
  logic [DW-1:0] best_den_r;

  logic [PW-1:0] diff;
  logic [CW-1:0] gx, gy;
  logic [DW-1:0] d2;
  logic [NW-1:0] num;
  logic [NW+DW-1:0] prod_new, prod_best;

  logic [QW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          rem_ge;
  logic [4:0]    cnt_r;
  logic [RW-1:0] sq_r, sq_bit_r, sq_t;
  logic [2*RW-1:0] sq_t2;

  logic          out_valid_r;
  logic [RW-1:0] out_slope_r;
  logic          out_bad_r;

  assign rd_addr = cmd.scan ? {qy_r, qx_r} : {in_y, in_x};

  always_ff @(posedge clk) begin
    if (cmd.pix_wr) begin
      mem[{in_y, in_x}] <= in_pixel;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = SW'(1);
    end else if (cfg_data > sdss_pkg::SIZE_MAX) begin
      cfg_clamped = sdss_pkg::SIZE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sdss_pkg::SIZE_MAX;
      height_r <= sdss_pkg::SIZE_MAX;
    end else if (cfg_valid) begin
      if (cfg_index == sdss_pkg::CFG_WIDTH) begin
        width_r <= cfg_clamped;
      end else begin
        height_r <= cfg_clamped;
      end
    end
  end

  assign diff = px_v_r - rd_data_r;
  assign gx   = (s1_qx_r > px_x_r) ? (s1_qx_r - px_x_r) : (px_x_r - s1_qx_r);
  assign gy   = (s1_qy_r > px_y_r) ? (s1_qy_r - px_y_r) : (px_y_r - s1_qy_r);
  assign d2   = DW'(gx * gx) + DW'(gy * gy);
  assign num  = NW'(diff * diff);

  assign prod_new  = s2_num_r * best_den_r;
  assign prod_best = best_num_r * s2_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.scan;
      s2_v_r <= s1_v_r && (rd_data_r < px_v_r) && (d2 != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      px_x_r <= in_x;
      px_y_r <= in_y;
    end
    if (cmd.px_load) begin
      px_v_r     <= rd_data_r;
      qx_r       <= '0;
      qy_r       <= '0;
      best_num_r <= '0;
      best_den_r <= DW'(1);
    end else begin
      if (cmd.scan) begin
        if ({1'b0, qx_r} == width_r - SW'(1)) begin
          qx_r <= '0;
          qy_r <= qy_r + CW'(1);
        end else begin
          qx_r <= qx_r + CW'(1);
        end
      end
      if (s2_v_r && (prod_new > prod_best)) begin
        best_num_r <= s2_num_r;
        best_den_r <= s2_d2_r;
      end
    end
    s1_qx_r  <= qx_r;
    s1_qy_r  <= qy_r;
    s2_num_r <= num;
    s2_d2_r  <= d2;
  end

  assign rem_sh  = {rem_r, q_r[QW-1]};
  assign rem_ge  = rem_sh >= {1'b0, best_den_r};
  assign rem_sub = rem_sh - {1'b0, best_den_r};
  assign sq_t    = sq_r | sq_bit_r;
  assign sq_t2   = sq_t * sq_t;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_r      <= {best_num_r, {(QW-NW){1'b0}}};
      rem_r    <= '0;
      cnt_r    <= '0;
      sq_r     <= '0;
      sq_bit_r <= {1'b1, {(RW-1){1'b0}}};
    end else begin
      if (cmd.div_run) begin
        q_r   <= {q_r[QW-2:0], rem_ge};
        rem_r <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        cnt_r <= cnt_r + 5'd1;
      end
      if (cmd.sqrt_run) begin
        if (sq_t2 <= q_r) begin
          sq_r <= sq_t;
        end
        sq_bit_r <= sq_bit_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slope_r <= cmd.out_bad ? '0 : sq_r;
      out_bad_r   <= cmd.out_bad;
    end
  end

  assign sts.in_inside = ({1'b0, in_x} < width_r) && ({1'b0, in_y} < height_r);
  assign sts.scan_last = ({1'b0, qx_r} == width_r - SW'(1)) &&
                         ({1'b0, qy_r} == height_r - SW'(1));
  assign sts.pipe_busy = s1_v_r || s2_v_r;
  assign sts.div_last  = (cnt_r == 5'd31);
  assign sts.sqrt_last = sq_bit_r[0];
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_slope_q8  = out_slope_r;
  assign out_bad_coord = out_bad_r;

endmodule

[rtl/sdss_checker.sv]
// Port-level checker for the steepest downward slope search unit.
// Bound to steepest_downward_slope_search_unit; depends on sdss_pkg.
module sdss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_action,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [sdss_pkg::SLOPE_W-1:0] out_slope_q8,
  input logic                         out_bad_coord
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("Reset did not clear the result and input handshake.");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_coord) |-> (out_slope_q8 == '0))
    else $error("A bad coordinate result carries a nonzero slope.");

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_action == sdss_pkg::ACT_QUERY)) |=> in_stall)
    else $error("A query was followed by an accept in the next cycle.");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_slope_q8)))
    else $error("A stalled result changed or vanished.");

endmodule

bind steepest_downward_slope_search_unit sdss_checker u_sdss_checker (.*);

[sim/steepest_downward_slope_search_unit_check.sv]
// Checker for the steepest downward slope search unit.
// Watches the in_, out_ and cfg_ channels, predicts every result and counts mismatches.
// Depends on sdss_pkg.
module steepest_downward_slope_search_unit_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_action,
  input  logic [sdss_pkg::COORD_W-1:0] in_x,
  input  logic [sdss_pkg::COORD_W-1:0] in_y,
  input  logic [sdss_pkg::PIX_W-1:0]   in_pixel,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [sdss_pkg::SLOPE_W-1:0] out_slope_q8,
  input  logic                         out_bad_coord,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [sdss_pkg::SIZE_W-1:0]  cfg_data,
  output int                           errors,
  output int                           pending,
  output int                           checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sdss_pkg::*;

  typedef struct {
    logic [SLOPE_W-1:0] slope_q8;
    logic               bad_coord;
  } slope_result_t;

  logic [PIX_W-1:0] image [MAX_SIDE*MAX_SIDE];
  int               img_w;
  int               img_h;
  slope_result_t    expected_slopes[$];

  function automatic int clamp_size(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic logic [SLOPE_W-1:0] steepest_slope(int px, int py);
    longint best_num;
    longint best_den;
    longint diff;
    longint d2;
    longint quo;
    longint root;
    longint trial;
    int vp;
    best_num = 0;
    best_den = 1;
    vp = image[py*MAX_SIDE + px];
    for (int qy = 0; qy < img_h; qy++) begin
      for (int qx = 0; qx < img_w; qx++) begin
        diff = vp - int'(image[qy*MAX_SIDE + qx]);
        d2 = (qx - px) * (qx - px) + (qy - py) * (qy - py);
        if (diff > 0 && d2 != 0 && diff * diff * best_den > best_num * d2) begin
          best_num = diff * diff;
          best_den = d2;
        end
      end
    end
    quo = (best_num << 16) / best_den;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= quo) root = trial;
    end
    return SLOPE_W'(root);
  endfunction

  assign pending = expected_slopes.size();

  always @(posedge clk) begin
    slope_result_t exp_r;
    if (!rst_n) begin
      img_w = MAX_SIDE;
      img_h = MAX_SIDE;
      errors = 0;
      checked = 0;
      expected_slopes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_slopes.size() == 0) begin
          $error("result with no query waiting: slope_q8 %0d bad_coord %0d",
                 out_slope_q8, out_bad_coord);
          errors++;
        end else begin
          exp_r = expected_slopes.pop_front();
          checked++;
          if (out_slope_q8 !== exp_r.slope_q8) begin
            $error("slope_q8: expected %0d, actual %0d", exp_r.slope_q8, out_slope_q8);
            errors++;
          end
          if (out_bad_coord !== exp_r.bad_coord) begin
            $error("bad_coord: expected %0d, actual %0d", exp_r.bad_coord, out_bad_coord);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_x < img_w && in_y < img_h) begin
          if (in_action == ACT_WRITE) begin
            image[in_y*MAX_SIDE + in_x] = in_pixel;
          end else begin
            exp_r.slope_q8 = steepest_slope(in_x, in_y);
            exp_r.bad_coord = 1'b0;
            expected_slopes.push_back(exp_r);
          end
        end else if (in_action == ACT_QUERY) begin
          exp_r.slope_q8 = '0;
          exp_r.bad_coord = 1'b1;
          expected_slopes.push_back(exp_r);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) img_w = clamp_size(cfg_data);
        else img_h = clamp_size(cfg_data);
      end
    end
  end

endmodule

[sim/steepest_downward_slope_search_unit_test.sv]
// Top of the testbench for the steepest downward slope search unit.
// Drives pixel writes, slope queries and size settings; the checker module predicts and compares.
// Depends on sdss_pkg, steepest_downward_slope_search_unit and its checker.
module steepest_downward_slope_search_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sdss_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_action;
  logic [COORD_W-1:0]  in_x;
  logic [COORD_W-1:0]  in_y;
  logic [PIX_W-1:0]    in_pixel;
  logic                out_valid;
  logic                out_stall;
  logic [SLOPE_W-1:0]  out_slope_q8;
  logic                out_bad_coord;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [SIZE_W-1:0]   cfg_data;
  int                  errors;
  int                  pending;
  int                  checked;
  int                  items_sent;
  int                  settings_used;
  int                  results_seen;
  bit                  calm;
  bit                  long_hold_done;
  int                  cur_w;
  int                  cur_h;

  steepest_downward_slope_search_unit uut (.*);

  steepest_downward_slope_search_unit_check slope_check (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #10ms;
    $display("steepest_downward_slope_search_unit_test: done, errors");
    $finish;
  end

  initial begin
    int n;
    out_stall = 1'b0;
    results_seen = 0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 3);
      if (!long_hold_done && results_seen >= 30) begin
        n = 300;
        long_hold_done = 1'b1;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      results_seen++;
    end
  end

  task automatic send_item(logic act, int x, int y, int pix);
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_x <= COORD_W'(x);
    in_y <= COORD_W'(y);
    in_pixel <= PIX_W'(pix);
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_size(logic idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= SIZE_W'(val);
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic int clamp_size(int v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  task automatic resize(int wv, int hv, bit extreme_fill);
    int pix;
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_size(CFG_WIDTH, wv);
    write_size(CFG_HEIGHT, hv);
    cfg_valid <= 1'b0;
    settings_used++;
    cur_w = clamp_size(wv);
    cur_h = clamp_size(hv);
    for (int y = 0; y < cur_h; y++) begin
      for (int x = 0; x < cur_w; x++) begin
        pix = extreme_fill ? 255 : $urandom_range(0, 255);
        send_item(ACT_WRITE, x, y, pix);
      end
    end
  endtask

  task automatic random_items(int count);
    int r;
    int pix;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      pix = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 255);
      if (r < 45)
        send_item(ACT_QUERY, $urandom_range(0, cur_w-1), $urandom_range(0, cur_h-1), pix);
      else if (r < 85)
        send_item(ACT_WRITE, $urandom_range(0, cur_w-1), $urandom_range(0, cur_h-1), pix);
      else if (r < 93)
        send_item(ACT_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), pix);
      else
        send_item(ACT_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), pix);
    end
  endtask

  initial begin
    items_sent = 0;
    settings_used = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_WRITE;
    in_x = '0;
    in_y = '0;
    in_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Zero sizes collapse to a single pixel, which has nothing lower.
    resize(0, 0, 1'b0);
    send_item(ACT_WRITE, 0, 0, 200);
    send_item(ACT_QUERY, 0, 0, 0);
    send_item(ACT_QUERY, 1, 0, 0);
    send_item(ACT_QUERY, 0, 63, 255);
    send_item(ACT_WRITE, 3, 3, 0);
    send_item(ACT_QUERY, 63, 63, 0);
    send_item(ACT_QUERY, 0, 0, 0);

    // A flat bright image with one dark corner gives the largest and the zero slopes.
    resize(5, 4, 1'b1);
    send_item(ACT_WRITE, 0, 0, 0);
    send_item(ACT_QUERY, 1, 0, 0);
    send_item(ACT_QUERY, 4, 3, 0);
    send_item(ACT_QUERY, 0, 0, 0);
    send_item(ACT_QUERY, 5, 0, 0);
    send_item(ACT_QUERY, 0, 4, 0);
    send_item(ACT_WRITE, 7, 7, 17);
    send_item(ACT_WRITE, 0, 0, 255);
    send_item(ACT_QUERY, 2, 2, 0);

    resize(100, 2, 1'b0);
    random_items(80);
    resize(1, 127, 1'b0);
    random_items(60);
    resize(7, 3, 1'b0);
    random_items(60);
    calm = 1'b1;
    resize(8, 8, 1'b0);
    random_items(60);
    calm = 1'b0;
    resize(33, 3, 1'b0);
    random_items(60);
    resize(2, 2, 1'b0);
    random_items(40);

    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d items over %0d size settings; %0d results checked.",
             items_sent, settings_used, checked);
    if (errors == 0)
      $display("steepest_downward_slope_search_unit_test: done, clean");
    else
      $display("steepest_downward_slope_search_unit_test: done, errors");
    $finish;
  end

endmodule

[files.f]
rtl/sdss_pkg.sv
rtl/sdss_ctrl.sv
rtl/sdss_dp.sv
rtl/steepest_downward_slope_search_unit.sv
rtl/sdss_checker.sv
sim/steepest_downward_slope_search_unit_check.sv
sim/steepest_downward_slope_search_unit_test.sv
